[rtl/dcsfb_pkg.sv]
`timescale 1ns / 1ps

package dcsfb_pkg;

	// Sizes of the chain and of each device queue
	localparam int MAX_DEVICES = 32;
	localparam int QUEUE_DEPTH = 16;

	// Field widths
	localparam int WORD_W     = 16;
	localparam int DEV_W      = 6;
	localparam int PTR_W      = $clog2(QUEUE_DEPTH);
	localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int CELL_IDX_W = $clog2(MAX_DEVICES);

	// Reduction tree shape
	localparam int TREE_GRP  = 8;
	localparam int TREE_NGRP = (MAX_DEVICES + TREE_GRP - 1) / TREE_GRP;

	// Input item kinds
	typedef enum logic {
		FUNC_PUSH  = 1'b0,
		FUNC_FRAME = 1'b1
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_DEV = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_CHAIN_LEN    = 1'b0,
		REG_FRAME_MARKER = 1'b1
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SETTLE,
		SEQ_OUT
	} seq_state_t;

	// Control from the sequencer to one queue cell
	typedef struct packed {
		logic wr;
		logic load;
		logic shift;
		logic active;
	} cell_ctrl_t;

	// Status from one queue cell
	typedef struct packed {
		logic busy;
		logic multi;
		logic full;
	} cell_stat_t;

endpackage

[rtl/dcsfb_cell.sv]
`timescale 1ns / 1ps

module dcsfb_cell
	import dcsfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [WORD_W-1:0] cmd,
	input  logic [WORD_W-1:0] shift_in,
	output logic [WORD_W-1:0] shift_out,
	output cell_stat_t        stat
);

	logic [WORD_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [FILL_W-1:0] fill_q;
	logic [WORD_W-1:0] sh_q;
	logic [PTR_W-1:0]  slot;
	logic              nonempty;
	logic              pop;

	assign nonempty = (fill_q != '0);
	assign pop      = ctrl.load & ctrl.active & nonempty;
	assign slot     = head_q + fill_q[PTR_W-1:0];

	// Store the pushed word at the tail
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			mem_q[slot] <= cmd;
		end
	end

	// Advance head and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (ctrl.wr) begin
			fill_q <= fill_q + FILL_W'(1);
		end else if (pop) begin
			head_q <= head_q + PTR_W'(1);
			fill_q <= fill_q - FILL_W'(1);
		end
	end

	// Load the head word into the frame chain, then pass it along
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sh_q <= pop ? mem_q[head_q] : '0;
		end else if (ctrl.shift) begin
			sh_q <= shift_in;
		end
	end

	assign shift_out  = sh_q;
	assign stat.busy  = ctrl.active & nonempty;
	assign stat.multi = ctrl.active & (fill_q > FILL_W'(1));
	assign stat.full  = (fill_q == FILL_W'(QUEUE_DEPTH));

endmodule

[rtl/dcsfb_empty_tree.sv]
`timescale 1ns / 1ps

module dcsfb_empty_tree
	import dcsfb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [MAX_DEVICES-1:0] busy,
	input  logic [MAX_DEVICES-1:0] multi,
	output logic                   all_empty,
	output logic                   frame_empty
);

	logic [TREE_NGRP-1:0] grp_busy;
	logic [TREE_NGRP-1:0] grp_multi;
	logic [TREE_NGRP-1:0] grp_busy_s1;
	logic [TREE_NGRP-1:0] grp_multi_s1;

	// OR each group of cells
	always_comb begin
		grp_busy  = '0;
		grp_multi = '0;
		for (int g = 0; g < TREE_NGRP; g++) begin
			for (int j = 0; j < TREE_GRP; j++) begin
				if (g * TREE_GRP + j < MAX_DEVICES) begin
					grp_busy[g]  = grp_busy[g]  | busy[g * TREE_GRP + j];
					grp_multi[g] = grp_multi[g] | multi[g * TREE_GRP + j];
				end
			end
		end
	end

	// Register group results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_busy_s1  <= '0;
			grp_multi_s1 <= '0;
		end else begin
			grp_busy_s1  <= grp_busy;
			grp_multi_s1 <= grp_multi;
		end
	end

	// Final OR of the registered groups
	assign all_empty   = ~(|grp_busy_s1);
	assign frame_empty = ~(|grp_multi_s1);

endmodule

[rtl/daisy_chain_spi_frame_builder_unit.sv]
`timescale 1ns / 1ps

// Command framer for a daisy chain of SPI devices. Each device has its own
// 16-deep queue of 16-bit commands held in one cell of a chain of 32 cells.
// The chain length register N sets how many devices are in use (0 acts as 1,
// above 32 acts as 32). A push word (tuser=0) queues a command for device
// 1..N and returns one result: status ok, invalid device or queue full. A
// frame word (tuser=1) returns N+1 words: the marker, then the head of each
// queue from the highest device down (zero for an empty queue), last on the
// final one. All non-empty queues in use pop together when the frame starts,
// and the words then shift along the cell chain toward the output, one per
// cycle while the sink is ready. Every result flags whether all queues in use
// are empty afterward. The first result is registered after a settle state
// that lets the registered empty-flag tree catch up; a frame then delivers one
// word per cycle while the sink is ready. A new input word is taken the cycle
// after the last result of the previous one is accepted.
module daisy_chain_spi_frame_builder_unit
	import dcsfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [5:0] device, [21:6] command, [23:22] zero
	input  logic [0:0]  s_tuser,  // [0] func
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] word
	output logic        m_tlast,
	output logic [2:0]  m_tuser   // [1:0] status, [2] all_empty
);

	seq_state_t        state_q, state_nxt;
	logic [DEV_W-1:0]  chain_len_q;
	logic [WORD_W-1:0] frame_marker_q;
	logic [DEV_W-1:0]  act_n;
	func_t             func_q;
	logic [DEV_W-1:0]  dev_q;
	logic [WORD_W-1:0] cmd_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_last_q;
	status_t           out_status_q;
	logic              out_empty_q;
	logic [DEV_W-1:0]  word_cnt_q;
	logic [DEV_W-1:0]  word_cnt_nxt;
	logic              in_acc;
	logic              out_acc;
	logic              cfg_wr;
	logic              frame_go;
	logic              push_go;
	logic              dev_ok;
	logic              dev_full;
	logic [CELL_IDX_W-1:0] dev_idx;
	status_t           push_status;
	logic              all_empty;
	logic              frame_empty;
	logic [MAX_DEVICES-1:0] busy_vec;
	logic [MAX_DEVICES-1:0] multi_vec;
	logic [MAX_DEVICES-1:0] full_vec;
	logic [WORD_W-1:0] chain [MAX_DEVICES+1];
	cell_ctrl_t        cell_ctrl [MAX_DEVICES];

	assign in_acc  = s_tvalid & s_tready;
	assign out_acc = out_valid_q & m_tready;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_len_q    <= DEV_W'(1);
			frame_marker_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2])) 
				REG_CHAIN_LEN:    chain_len_q    <= pwdata[DEV_W-1:0];
				REG_FRAME_MARKER: frame_marker_q <= pwdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_CHAIN_LEN:    prdata = 32'(chain_len_q);
			REG_FRAME_MARKER: prdata = 32'(frame_marker_q);
			default:          prdata = '0;
		endcase
	end

	// Clamp the device count into 1..MAX_DEVICES
	always_comb begin
		if (chain_len_q == '0) begin
			act_n = DEV_W'(1);
		end else if (chain_len_q > DEV_W'(MAX_DEVICES)) begin
			act_n = DEV_W'(MAX_DEVICES);
		end else begin
			act_n = chain_len_q;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func_t'(s_tuser[0]);
			dev_q  <= s_tdata[DEV_W-1:0];
			cmd_q  <= s_tdata[DEV_W+WORD_W-1:DEV_W];
		end
	end

	// Decode the push target
	assign dev_idx  = CELL_IDX_W'(dev_q - DEV_W'(1));
	assign dev_ok   = (dev_q != '0) && (dev_q <= act_n);
	assign dev_full = full_vec[dev_idx];

	always_comb begin
		if (!dev_ok) begin
			push_status = ST_BAD_DEV;
		end else if (dev_full) begin
			push_status = ST_FULL;
		end else begin
			push_status = ST_OK;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			SEQ_IDLE:   if (in_acc) state_nxt = SEQ_SETTLE;
			SEQ_SETTLE: state_nxt = SEQ_OUT;
			SEQ_OUT:    if (out_acc && out_last_q) state_nxt = SEQ_IDLE;
			default:    state_nxt = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		frame_go = 1'b0;
		push_go  = 1'b0;
		case (state_q)
			SEQ_IDLE:   s_tready = 1'b1;
			SEQ_SETTLE: begin
				frame_go = (func_q == FUNC_FRAME);
				push_go  = (func_q == FUNC_PUSH);
			end
			SEQ_OUT:    ;
			default:    ;
		endcase
	end

	assign word_cnt_nxt = word_cnt_q + DEV_W'(1);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			word_cnt_q  <= '0;
		end else if (push_go || frame_go) begin
			out_valid_q <= 1'b1;
			word_cnt_q  <= '0;
		end else if (out_acc) begin
			out_valid_q <= ~out_last_q;
			word_cnt_q  <= word_cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (push_go) begin
			out_word_q   <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= push_status;
			out_empty_q  <= (push_status == ST_OK) ? 1'b0 : all_empty;
		end else if (frame_go) begin
			out_word_q   <= frame_marker_q;
			out_last_q   <= 1'b0;
			out_status_q <= ST_OK;
			out_empty_q  <= frame_empty;
		end else if (out_acc) begin
			out_word_q   <= chain[act_n];
			out_last_q   <= (word_cnt_nxt == act_n);
		end
	end

	// Cell chain: cell i holds device i+1, words move up toward the tap
	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_DEVICES; i++) begin : g_cell
		assign cell_ctrl[i].wr     = push_go && dev_ok && !dev_full &&
		                             (dev_idx == CELL_IDX_W'(i));
		assign cell_ctrl[i].load   = frame_go;
		assign cell_ctrl[i].shift  = out_acc;
		assign cell_ctrl[i].active = (DEV_W'(i) < act_n);

		dcsfb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl[i]),
			.cmd       (cmd_q),
			.shift_in  (chain[i]),
			.shift_out (chain[i+1]),
			.stat      ({busy_vec[i], multi_vec[i], full_vec[i]})
		);
	end

	dcsfb_empty_tree u_tree (
		.clk         (clk),
		.arst_n      (arst_n),
		.busy        (busy_vec),
		.multi       (multi_vec),
		.all_empty   (all_empty),
		.frame_empty (frame_empty)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_empty_q, out_status_q};

	// Never take input while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while result pending");

	// A push gives one zero word marked last
	a_push_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && func_q == FUNC_PUSH) |-> (m_tdata == '0 && m_tlast))
		else $error("malformed push result");

	// Frame word count stays within the active chain
	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_OUT && func_q == FUNC_FRAME) |-> (word_cnt_q <= act_n))
		else $error("frame word count overrun");

	// Nothing follows the last word of an item
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("result after last word");

endmodule
